/* hdl/gbed_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gbed_pkg
// Shared types and constants for the gray to bilevel error diffusion block.
// ----------------------------------------------------------------------------
package gbed_pkg;

  // pixel and error widths
  localparam int PIX_W      = 8;
  localparam int ERR_W      = 18;
  localparam int THR_W      = 9;
  localparam int IMG_W_W    = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // default line length
  localparam int DEF_MAX_WIDTH = 1024;

  // register reset values
  localparam logic               MODE_RESET      = 1'b1;
  localparam logic [THR_W-1:0]   THRESHOLD_RESET = 9'd128;
  localparam logic [IMG_W_W-1:0] IMG_WIDTH_RESET = 11'd1024;

  // diffusion decision: dark below 256*128, white level 256*255
  localparam int DARK_LIMIT = 32768;
  localparam int FULL_SCALE = 65280;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE        = 2'd0,
    REG_THRESHOLD   = 2'd1,
    REG_IMAGE_WIDTH = 2'd2
  } cfg_reg_t;

endpackage : gbed_pkg
`default_nettype wire

/* hdl/gbed_line_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gbed_line_store
// One-row error store: one write port, one registered read port. The read
// register takes a same-edge write to its address and follows later writes
// to the address of the pixel it serves while that pixel waits.
// ----------------------------------------------------------------------------
module gbed_line_store #(
  parameter int DEPTH = gbed_pkg::DEF_MAX_WIDTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [AW-1:0]            wr_addr,
  input  wire logic [gbed_pkg::ERR_W-1:0] wr_data,
  input  wire logic                     rd_en,
  input  wire logic [AW-1:0]            rd_addr,
  input  wire logic [AW-1:0]            hold_addr,
  output      logic [gbed_pkg::ERR_W-1:0] rd_data
);
  import gbed_pkg::*;

  logic [ERR_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port with write bypass
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && wr_addr == rd_addr) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end else if (wr_en && wr_addr == hold_addr) begin
      rd_data <= wr_data;
    end
  end

endmodule : gbed_line_store
`default_nettype wire

/* hdl/gray_to_bilevel_error_diffusion.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gray_to_bilevel_error_diffusion
// Converts 8-bit gray pixels to 1-bit dark marks, by fixed threshold or by
// error diffusion with 7/3/5/1 weights, packed eight to a byte.
//
//   channel  dir  fields
//   s_*      in   tdata[7:0] pixel_value, tuser first_of_image
//   m_*      out  tdata[7:0] packed_bits, tlast end_of_row
//   cfg_*    in   cfg_index register, cfg_data value (always ready)
//
// One pixel per cycle sustained. A pixel is registered on acceptance while
// its line store entry is read, and is resolved from that register into the
// carry registers, the store write and the output byte register.
// The input stalls only when a byte is due and a full output is not taken.
// Reset is synchronous; the line store holds no reset and needs no clearing.
// ----------------------------------------------------------------------------
module gray_to_bilevel_error_diffusion #(
  parameter int MAX_WIDTH = gbed_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // pixel input
  input  wire logic                          s_tvalid,
  output      logic                          s_tready,
  input  wire logic [7:0]                    s_tdata,   // [7:0] pixel_value
  input  wire logic                          s_tuser,   // [0] first_of_image
  // packed output
  output      logic                          m_tvalid,
  input  wire logic                          m_tready,
  output      logic [7:0]                    m_tdata,   // [7:0] packed_bits
  output      logic                          m_tlast,
  // configuration writes
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [gbed_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gbed_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gbed_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int LW = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;
  localparam int VW = ERR_W + 2;
  localparam logic [LW-1:0] MAX_W_L = LW'(MAX_WIDTH);
  localparam logic signed [VW-1:0] DARK_V = VW'(DARK_LIMIT);
  localparam logic signed [VW-1:0] FULL_V = VW'(FULL_SCALE);

  // configuration registers
  logic               mode;
  logic [THR_W-1:0]   threshold;
  logic [IMG_W_W-1:0] image_width;

  // accept side
  logic [CW-1:0] col_cnt;
  logic [LW-1:0] width_l;
  logic [LW-1:0] width_eff;
  logic [CW-1:0] w_last;
  logic [CW-1:0] in_col;
  logic          in_last;
  logic          accept;

  // pixel register
  logic          s1_valid;
  logic [7:0]    s1_pixel;
  logic          s1_first;
  logic [CW-1:0] s1_col;
  logic          s1_last;

  // row state
  logic signed [ERR_W-1:0] right_carry;
  logic signed [ERR_W-1:0] below_a;
  logic signed [ERR_W-1:0] below_b;
  logic                    first_row;
  logic [7:0]              collector;

  // pending tail write
  logic             pend_valid;
  logic [CW-1:0]    pend_addr;
  logic [ERR_W-1:0] pend_data;

  // line store ports
  logic             wr_main;
  logic             st_wr_en;
  logic [CW-1:0]    st_wr_addr;
  logic [ERR_W-1:0] st_wr_data;
  logic [ERR_W-1:0] st_rd_data;

  // datapath
  logic signed [ERR_W-1:0] rc_eff, a_eff, b_eff;
  logic                    first_row_eff;
  logic [7:0]              coll_eff;
  logic [ERR_W-1:0]        stored_raw;
  logic signed [ERR_W-1:0] stored;
  logic signed [VW-1:0]    val;
  logic signed [VW-1:0]    err;
  logic signed [VW-1:0]    err_adj;
  logic signed [VW-1:0]    quot;
  logic signed [VW-1:0]    d;
  logic signed [VW-1:0]    d3, d5, d7;
  logic signed [VW-1:0]    sum_store, sum_a;
  logic                    dark;
  logic [7:0]              coll_new;
  logic                    emit;
  logic                    consume;

  assign cfg_ready = 1'b1;

  // configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_RESET;
      threshold   <= THRESHOLD_RESET;
      image_width <= IMG_WIDTH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:        mode        <= cfg_data[0];
        REG_THRESHOLD:   threshold   <= cfg_data[THR_W-1:0];
        REG_IMAGE_WIDTH: image_width <= cfg_data[IMG_W_W-1:0];
        default: ;
      endcase
    end
  end

  // effective row length and column of the arriving pixel
  always_comb begin
    width_l = LW'(image_width);
    if (width_l == '0) begin
      width_eff = LW'(1);
    end else if (width_l > MAX_W_L) begin
      width_eff = MAX_W_L;
    end else begin
      width_eff = width_l;
    end
    w_last = CW'(width_eff - LW'(1));
    if (s_tuser) begin
      in_col = '0;
    end else if (col_cnt > w_last) begin
      in_col = w_last;
    end else begin
      in_col = col_cnt;
    end
    in_last = (in_col == w_last);
  end

  assign accept   = s_tvalid && s_tready;
  assign s_tready = !s1_valid || consume;

  // column counter
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
    end else if (accept) begin
      col_cnt <= in_last ? '0 : in_col + CW'(1);
    end
  end

  // pixel register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (consume) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel <= s_tdata;
      s1_first <= s_tuser;
      s1_col   <= in_col;
      s1_last  <= in_last;
    end
  end

  // row state as seen by this pixel, cleared by a new image
  always_comb begin
    if (s1_first) begin
      rc_eff        = '0;
      a_eff         = '0;
      b_eff         = '0;
      first_row_eff = 1'b1;
      coll_eff      = '0;
    end else begin
      rc_eff        = right_carry;
      a_eff         = below_a;
      b_eff         = below_b;
      first_row_eff = first_row;
      coll_eff      = collector;
    end
  end

  // decision and error split
  always_comb begin
    stored_raw = (pend_valid && pend_addr == s1_col) ? pend_data : st_rd_data;
    stored     = first_row_eff ? '0 : $signed(stored_raw);
    val        = $signed({{(VW-16){1'b0}}, s1_pixel, 8'h00}) + VW'(stored) + VW'(rc_eff);
    err        = (val < DARK_V) ? val : val - FULL_V;
    // divide by 16 truncating toward zero
    err_adj    = err[VW-1] ? err + VW'(15) : err;
    quot       = err_adj >>> 4;
    d          = mode ? quot : '0;
    d3         = (d <<< 1) + d;
    d5         = (d <<< 2) + d;
    d7         = (d <<< 3) - d;
    sum_store  = VW'(a_eff) + d3;
    sum_a      = VW'(b_eff) + d5;
    if (mode) begin
      dark = (val < DARK_V);
    end else begin
      dark = ({1'b0, s1_pixel} < threshold);
    end
    coll_new = coll_eff | (8'(dark) << s1_col[2:0]);
    emit     = s1_last || (s1_col[2:0] == 3'd7);
  end

  assign consume = s1_valid && (!emit || !m_tvalid || m_tready);

  // carries, row flag and bit collector
  always_ff @(posedge clk) begin
    if (rst) begin
      right_carry <= '0;
      below_a     <= '0;
      below_b     <= '0;
      first_row   <= 1'b1;
      collector   <= '0;
    end else if (consume) begin
      if (s1_last) begin
        right_carry <= '0;
        below_a     <= '0;
        below_b     <= '0;
        first_row   <= 1'b0;
      end else begin
        right_carry <= d7[ERR_W-1:0];
        below_a     <= sum_a[ERR_W-1:0];
        below_b     <= d[ERR_W-1:0];
        first_row   <= first_row_eff;
      end
      collector <= emit ? '0 : coll_new;
    end
  end

  // row end leaves a second store write, issued once the port is free
  assign wr_main = consume && (s1_col != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (consume && s1_last) begin
      pend_valid <= 1'b1;
    end else if (!wr_main) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && s1_last) begin
      pend_addr <= s1_col;
      pend_data <= sum_a[ERR_W-1:0];
    end
  end

  // store write select
  always_comb begin
    st_wr_en = wr_main || pend_valid;
    if (wr_main) begin
      st_wr_addr = s1_col - CW'(1);
      st_wr_data = sum_store[ERR_W-1:0];
    end else begin
      st_wr_addr = pend_addr;
      st_wr_data = pend_data;
    end
  end

  gbed_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_store (
    .clk       (clk),
    .wr_en     (st_wr_en),
    .wr_addr   (st_wr_addr),
    .wr_data   (st_wr_data),
    .rd_en     (accept),
    .rd_addr   (in_col),
    .hold_addr (s1_col),
    .rd_data   (st_rd_data)
  );

  // output byte register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (consume && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && emit) begin
      m_tdata <= coll_new;
      m_tlast <= s1_last;
    end
  end

endmodule : gray_to_bilevel_error_diffusion
`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gray to bilevel error diffusion block. Gray
// pixel requests are queued by a stimulus thread and sent by a clocked
// driver. A local dithering model predicts every packed byte, and a monitor
// compares each output request against the oldest prediction. The run covers
// both modes, the register extremes, width changes and restarts within rows,
// random gaps on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import gbed_pkg::*;

  localparam int MAX_W         = DEF_MAX_WIDTH;
  localparam int RAND_ITEMS    = 760;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 200;
  localparam int QUIET_LIMIT   = 3000;

  // pixel content patterns for a phase
  typedef enum int {TONE_NOISE, TONE_FLAT, TONE_RAMP, TONE_EXTREME} tone_t;

  typedef struct packed {
    logic [7:0] level;
    logic       first;
  } pixel_req_t;

  typedef struct packed {
    logic [7:0] bits;
    logic       row_end;
  } packed_byte_t;

  // dut ports
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata   = '0;   // [7:0] pixel_value
  logic                  s_tuser   = 1'b0; // [0] first_of_image
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [7:0]            m_tdata;          // [7:0] packed_bits
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // stimulus and checking state
  pixel_req_t   pix_requests [$];
  packed_byte_t bytes_due    [$];
  bit           pix_taken    = 1'b0;
  bit           in_steady    = 1'b0;
  bit           out_steady   = 1'b0;
  bit           hold_off_req = 1'b0;
  bit           restart_due  = 1'b0;
  int           gen_width    = MAX_W;
  int           in_gap       = 0;
  int           out_stall    = 0;
  int           quiet_cycles = 0;
  int           pixels_queued = 0;
  int           pixels_taken  = 0;
  int           bytes_seen    = 0;
  int           reg_writes    = 0;
  int           mismatches    = 0;
  int           rows_closed   = 0;
  int           restarts      = 0;
  int           dark_count    = 0;

  // shadow registers and dithering state
  bit           diff_mode = MODE_RESET;
  logic [8:0]   fixed_thr = THRESHOLD_RESET;
  logic [10:0]  row_len   = IMG_WIDTH_RESET;
  int           err_line [MAX_W];
  int           err_right      = 0;
  int           err_below_prev = 0;
  int           err_below_here = 0;
  int           col_next       = 0;
  bit           top_row        = 1'b1;
  logic [7:0]   dark_bits      = '0;

  gray_to_bilevel_error_diffusion i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial forever #2 clk = ~clk;

  // error sums are kept as 18-bit two's complement
  function automatic int wrap18(int v);
    logic signed [ERR_W-1:0] t;
    t = v[ERR_W-1:0];
    return int'(t);
  endfunction

  // one pixel through the dithering model, queueing any completed byte
  function automatic void diffuse_pixel(logic [7:0] level, logic first);
    int w;
    int col;
    int acc;
    int err;
    bit dark;
    bit last;
    w = (row_len == 0) ? 1 : int'(row_len);
    if (w > MAX_W) w = MAX_W;
    if (first) begin
      err_right      = 0;
      err_below_prev = 0;
      err_below_here = 0;
      col_next       = 0;
      top_row        = 1'b1;
      dark_bits      = '0;
      restarts++;
    end
    col = (col_next >= w) ? w - 1 : col_next;
    err = 0;
    if (diff_mode) begin
      acc  = 256 * int'(level) + (top_row ? 0 : err_line[col]) + err_right;
      dark = acc < DARK_LIMIT;
      err  = (dark ? acc : acc - FULL_SCALE) / 16;
    end else begin
      dark = {1'b0, level} < fixed_thr;
    end
    // spread 7/3/5/1 to right, lower-left, below and lower-right
    err_right = wrap18(7 * err);
    if (col > 0) err_line[col-1] = wrap18(err_below_prev + 3 * err);
    err_below_prev = wrap18(err_below_here + 5 * err);
    err_below_here = wrap18(err);
    if (dark) begin
      dark_bits[col & 7] = 1'b1;
      dark_count++;
    end
    last = (col == w - 1);
    if (last) begin
      err_line[col]  = err_below_prev;
      err_below_prev = 0;
      err_below_here = 0;
      err_right      = 0;
      col_next       = 0;
      top_row        = 1'b0;
      rows_closed++;
    end else begin
      col_next = col + 1;
    end
    if (last || (col & 7) == 7) begin
      bytes_due.push_back('{bits: dark_bits, row_end: last});
      dark_bits = '0;
    end
  endfunction

  function automatic void note_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t ns: %s", $time, what);
  endfunction

  // idle length: mostly none, sometimes short, rarely long
  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] shade(tone_t tone, int base, int x, int w);
    int v;
    case (tone)
      TONE_NOISE: v = int'($urandom_range(0, 255));
      TONE_FLAT:  v = base + int'($urandom_range(0, 6)) - 3;
      TONE_RAMP:  v = (x * 255) / ((w > 1) ? w - 1 : 1) + int'($urandom_range(0, 4)) - 2;
      default:    v = $urandom_range(0, 1) ? 255 : 0;
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // a width that grows within an image would read unwritten line store
  // entries, so the next pixel then starts a new image
  function automatic void queue_pixel(logic [7:0] level, bit first);
    pixel_req_t req;
    req.level   = level;
    req.first   = first | restart_due;
    restart_due = 1'b0;
    pix_requests.push_back(req);
    pixels_queued++;
  endfunction

  task automatic set_reg(cfg_reg_t idx, logic [10:0] value);
    int eff;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
    if (idx == REG_IMAGE_WIDTH) begin
      eff = (value == 0) ? 1 : (value > MAX_W) ? MAX_W : int'(value);
      if (eff > gen_width) restart_due = 1'b1;
      gen_width = eff;
    end
  endtask

  // wait until every request is taken and every byte is back
  task automatic drain();
    while (pixels_taken != pixels_queued || bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // accepted requests: pixels into the model, register writes into shadows
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        diffuse_pixel(s_tdata, s_tuser);
        pix_taken = 1'b1;
        pixels_taken++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_MODE:        diff_mode = cfg_data[0];
          REG_THRESHOLD:   fixed_thr = cfg_data[8:0];
          REG_IMAGE_WIDTH: row_len   = cfg_data;
          default: ;
        endcase
      end
    end
  end

  // pixel driver
  always @(negedge clk) begin
    pixel_req_t req;
    logic       drive;
    drive = s_tvalid;
    if (rst) begin
      drive = 1'b0;
    end else if (!s_tvalid || pix_taken) begin
      pix_taken = 1'b0;
      drive     = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (pix_requests.size() > 0) begin
        req = pix_requests.pop_front();
        s_tdata <= req.level;
        s_tuser <= req.first;
        drive   = 1'b1;
        in_gap  = pick_gap(in_steady);
      end
    end
    s_tvalid <= drive;
  end

  // output ready with random stalls and one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (hold_off_req) begin
        out_stall    = LONG_HOLD;
        hold_off_req = 1'b0;
      end else if (out_stall == 0 && m_tready) begin
        out_stall = pick_gap(out_steady);
      end
      if (out_stall > 0) begin
        out_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // byte monitor
  always @(posedge clk) begin
    packed_byte_t want;
    if (!rst && m_tvalid && m_tready) begin
      bytes_seen++;
      if (bytes_due.size() == 0) begin
        note_mismatch($sformatf("byte %02h row end %0b with nothing due", m_tdata, m_tlast));
      end else begin
        want = bytes_due.pop_front();
        if (m_tdata !== want.bits || m_tlast !== want.row_end)
          note_mismatch($sformatf("bits exp %02h got %02h, row end exp %0b got %0b",
                                  want.bits, m_tdata, want.row_end, m_tlast));
      end
    end
  end

  // watchdog on cycles with no request accepted anywhere
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no request accepted for %0d cycles, %0d bytes still due",
               quiet_cycles, bytes_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus sequence
  initial begin
    int          n;
    int          rows;
    int          base;
    int          ph;
    int          rand_pixels;
    int          r;
    bit          fresh;
    tone_t       tone;
    logic [10:0] word;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // fixed threshold, one-pixel rows (width zero acts as one)
    set_reg(REG_MODE, 11'd0);
    set_reg(REG_THRESHOLD, 11'd128);
    set_reg(REG_IMAGE_WIDTH, 11'd0);
    queue_pixel(8'd0, 1'b1);
    queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd127, 1'b0);
    queue_pixel(8'd128, 1'b0);
    drain();
    // threshold past the pixel range marks everything dark
    set_reg(REG_THRESHOLD, 11'd256);
    queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd0, 1'b0);
    drain();
    set_reg(REG_THRESHOLD, 11'd0);
    queue_pixel(8'd0, 1'b0);
    queue_pixel(8'd255, 1'b0);
    drain();

    // diffusion over short rows with a restart in the second row
    set_reg(REG_MODE, 11'd1);
    set_reg(REG_IMAGE_WIDTH, 11'd5);
    queue_pixel(8'd0, 1'b0);
    queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd128, 1'b0);
    queue_pixel(8'd127, 1'b0);
    queue_pixel(8'd200, 1'b0);
    queue_pixel(8'd60, 1'b0);
    queue_pixel(8'd190, 1'b0);
    queue_pixel(8'd255, 1'b1);
    queue_pixel(8'd0, 1'b0);
    queue_pixel(8'd128, 1'b0);
    queue_pixel(8'd127, 1'b0);
    queue_pixel(8'd40, 1'b0);
    queue_pixel(8'd250, 1'b0);
    queue_pixel(8'd10, 1'b0);
    drain();
    // width cut below the current column closes the row at once
    set_reg(REG_IMAGE_WIDTH, 11'd2);
    queue_pixel(8'd128, 1'b0);
    drain();

    // full width, partial row, then shrunk mid-row
    set_reg(REG_IMAGE_WIDTH, 11'd1024);
    for (int i = 0; i < 40; i++) queue_pixel(shade(TONE_NOISE, 0, i, 40), i == 0);
    drain();
    set_reg(REG_IMAGE_WIDTH, 11'd16);
    for (int i = 0; i < 3; i++) queue_pixel(shade(TONE_NOISE, 0, i, 16), 1'b0);
    drain();
    // oversized width starts a long partial row for later phases to close
    set_reg(REG_IMAGE_WIDTH, 11'h7FF);
    for (int i = 0; i < 40; i++)
      queue_pixel(shade(TONE_RAMP, 0, i, MAX_W), 1'b0);
    drain();

    // random phases
    ph          = 0;
    rand_pixels = 0;
    while (rand_pixels < RAND_ITEMS || ph < 3) begin
      ph++;
      if (ph == 1 || $urandom_range(0, 2) != 0) begin
        word    = ($urandom_range(0, 3) == 0) ? 11'($urandom) : 11'd0;
        word[0] = ($urandom_range(0, 9) < 7);
        set_reg(REG_MODE, word);
      end
      if (ph == 1 || $urandom_range(0, 1) == 0) begin
        r = $urandom_range(0, 7);
        case (r)
          0:       word = 11'd0;
          1:       word = 11'd256;
          2:       word = 11'd255;
          3:       word = 11'($urandom_range(257, 2047));
          default: word = 11'($urandom_range(1, 254));
        endcase
        set_reg(REG_THRESHOLD, word);
      end
      if (ph == 1 || $urandom_range(0, 2) != 0) begin
        r = $urandom_range(0, 9);
        if (r < 6)       word = 11'($urandom_range(1, 24));
        else if (r < 8)  word = 11'($urandom_range(25, 70));
        else if (r == 8) word = 11'($urandom_range(71, 130));
        else             word = 11'($urandom_range(0, 1));
        set_reg(REG_IMAGE_WIDTH, word);
      end
      rows  = (gen_width > 70) ? $urandom_range(1, 2) : $urandom_range(1, 4);
      n     = rows * gen_width + $urandom_range(0, gen_width - 1);
      // keep the total near the planned pixel count
      if (n > RAND_ITEMS - rand_pixels) n = RAND_ITEMS - rand_pixels;
      if (n < 1) n = 1;
      tone  = tone_t'($urandom_range(0, 3));
      base  = $urandom_range(0, 255);
      fresh = ($urandom_range(0, 2) == 0);
      in_steady  = ($urandom_range(0, 3) == 0);
      out_steady = ($urandom_range(0, 3) == 0);
      // one phase keeps the input busy while the output holds off
      if (ph == 3) begin
        in_steady  = 1'b1;
        out_steady = 1'b0;
        if (n < 96) n = 96;
      end
      for (int i = 0; i < n; i++)
        queue_pixel(shade(tone, base, i % gen_width, gen_width),
                    (i == 0 && fresh) || $urandom_range(0, 119) == 0);
      if (ph == 3) hold_off_req = 1'b1;
      rand_pixels += n;
      drain();
    end

    repeat (16) @(posedge clk);
    $display("covered %0d pixels over %0d register writes and %0d random phases",
             pixels_taken, reg_writes, ph);
    $display("checked %0d bytes: %0d rows closed, %0d restarts, %0d dark pixels",
             bytes_seen, rows_closed, restarts, dark_count);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* gray_to_bilevel_error_diffusion.f */
hdl/gbed_pkg.sv
hdl/gbed_line_store.sv
hdl/gray_to_bilevel_error_diffusion.sv
sim/tb_top.sv
